FILE: sv/window_gated_position_capture_unit_assert.svh
// Assertion macros for the window gated position capture unit.
`ifndef WINDOW_GATED_POSITION_CAPTURE_UNIT_ASSERT_SVH
`define WINDOW_GATED_POSITION_CAPTURE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define WGPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define WGPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WGPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WGPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/wgpc_pkg.sv
// Shared types and constants of the window gated position capture unit.
package wgpc_pkg;

	localparam int POS_W  = 20;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 8;
	localparam int MODE_W = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 20;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH = 1'd1;

	// Reset values of the window bounds.
	localparam logic [POS_W-1:0] WINDOW_LOW_RESET  = 20'd2080;
	localparam logic [POS_W-1:0] WINDOW_HIGH_RESET = 20'd2100;

	// Encoder position and its window check for the current item.
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             in_window;
	} win_t;

	// One result item.
	typedef struct packed {
		logic             pulse_level;
		logic             trigger_level;
		logic             trigdat_strobe;
		logic             capture_valid;
		logic [IDX_W-1:0] capture_index;
		logic [POS_W-1:0] capture_position;
		logic             scan_done;
		logic             timed_out;
	} result_t;

endpackage

FILE: sv/window_gated_position_capture_unit.sv
// Top level of the window gated position capture unit.
//
//   Channel  Direction  Handshake               Contents
//   in       input      in_valid / in_ready     mode and three encoder bytes
//   out      output     out_valid / out_ready   pulse, trigger, capture and scan status
//   cfg      input      cfg_write_en            window_low (0), window_high (1)
//
// One result per item, one item per cycle sustained while the output is not
// stalled. An accepted item is registered in the input stage, where the window
// compare and the scan state update run, and its result is then loaded into the
// output register. Reset clears the scan state and loads the window defaults.
// While the output register is stalled, the input stage holds one more item,
// then in_ready drops.
module window_gated_position_capture_unit #(
	parameter int CAPTURE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wgpc_pkg::MODE_W-1:0]        mode,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_high_byte,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_mid_byte,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_low_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               pulse_level,
	output logic                               trigger_level,
	output logic                               trigdat_strobe,
	output logic                               capture_valid,
	output logic [wgpc_pkg::IDX_W-1:0]         capture_index,
	output logic [wgpc_pkg::POS_W-1:0]         capture_position,
	output logic                               scan_done,
	output logic                               timed_out,
	input  logic                               cfg_write_en,
	input  logic [wgpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wgpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wgpc_pkg::*;

	`include "window_gated_position_capture_unit_assert.svh"

	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [BYTE_W-1:0] high_s1;
	logic [BYTE_W-1:0] mid_s1;
	logic [BYTE_W-1:0] low_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res;
	win_t              win;
	logic              advance;
	logic              in_fire;

	// The output register frees up when empty or when its result transfers.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1 <= mode;
			high_s1 <= enc_high_byte;
			mid_s1  <= enc_mid_byte;
			low_s1  <= enc_low_byte;
		end
	end

	wgpc_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.enc_high_byte (high_s1),
		.enc_mid_byte  (mid_s1),
		.enc_low_byte  (low_s1),
		.win           (win)
	);

	wgpc_ctrl #(
		.CAPTURE_DEPTH (CAPTURE_DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.mode   (mode_s1),
		.win    (win),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign pulse_level      = res_q.pulse_level;
	assign trigger_level    = res_q.trigger_level;
	assign trigdat_strobe   = res_q.trigdat_strobe;
	assign capture_valid    = res_q.capture_valid;
	assign capture_index    = res_q.capture_index;
	assign capture_position = res_q.capture_position;
	assign scan_done        = res_q.scan_done;
	assign timed_out        = res_q.timed_out;

	// Consistency checks.
	`WGPC_ASSERT_IMPL(a_timeout_ends_scan, clk, arst_n,
		out_valid_q && res_q.timed_out, res_q.scan_done && !res_q.capture_valid,
		"timeout result without scan end or with a capture")
	`WGPC_ASSERT_IMPL(a_capture_on_rising, clk, arst_n,
		out_valid_q && res_q.capture_valid, res_q.trigdat_strobe && res_q.pulse_level,
		"capture outside a rising tick")
	`WGPC_ASSERT_IMPL(a_full_blocks_input, clk, arst_n,
		valid_s1 && out_valid_q && !out_ready, !in_ready,
		"input taken while both stages are stalled")
	`WGPC_ASSERT_NEXT(a_stage_moves, clk, arst_n,
		valid_s1 && advance, out_valid_q,
		"input stage item lost on its way to the output")

endmodule

FILE: sv/wgpc_window.sv
// Window bound registers, encoder position assembly and window compare.
module wgpc_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [wgpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wgpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_high_byte,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_mid_byte,
	input  logic [wgpc_pkg::BYTE_W-1:0]        enc_low_byte,
	output wgpc_pkg::win_t                     win
);
	import wgpc_pkg::*;

	logic [POS_W-1:0] window_low_q;
	logic [POS_W-1:0] window_high_q;
	logic [POS_W-1:0] position;

	// Window bound registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= WINDOW_LOW_RESET;
			window_high_q <= WINDOW_HIGH_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				REG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The low nibble of the last encoder byte carries no position bits.
	assign position = {enc_high_byte, enc_mid_byte, enc_low_byte[BYTE_W-1 -: 4]};

	// An inverted window never matches.
	assign win.position  = position;
	assign win.in_window = (position >= window_low_q) && (position <= window_high_q);

endmodule

FILE: sv/wgpc_ctrl.sv
// Scan state registers and the per-item result logic.
module wgpc_ctrl #(
	parameter int CAPTURE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [wgpc_pkg::MODE_W-1:0]  mode,
	input  wgpc_pkg::win_t               win,
	output wgpc_pkg::result_t            res
);
	import wgpc_pkg::*;

	localparam int CW = $clog2(CAPTURE_DEPTH + 1);

	logic          pulse_phase_q;
	logic          reading_enabled_q;
	logic          acquiring_q;
	logic [CW-1:0] capture_count_q;
	logic [POS_W-1:0] last_position_q;
	logic          timeout_armed_q;

	logic          phase_n;
	logic          reading_n;
	logic          acq_n;
	logic [CW-1:0] count_n;
	logic [POS_W-1:0] pos_n;
	logic          armed_n;
	logic [CW+IDX_W-1:0] count_ext;

	assign count_ext = {{IDX_W{1'b0}}, capture_count_q};

	// Next state and result for the item in the input stage.
	always_comb begin
		phase_n   = pulse_phase_q;
		reading_n = reading_enabled_q;
		acq_n     = acquiring_q;
		count_n   = capture_count_q;
		pos_n     = last_position_q;
		armed_n   = timeout_armed_q;
		res       = '0;
		case (mode)
			MODE_TICK: begin
				phase_n = !pulse_phase_q;
				if (phase_n) begin
					res.trigdat_strobe = 1'b1;
					if (reading_enabled_q) begin
						pos_n = win.position;
						acq_n = win.in_window;
					end
					// The acquire flag held before the tick decides on a capture.
					if (acquiring_q) begin
						armed_n = 1'b0;
						if (capture_count_q < CW'(CAPTURE_DEPTH)) begin
							res.capture_valid    = 1'b1;
							res.capture_index    = count_ext[IDX_W-1:0];
							res.capture_position = pos_n;
							count_n              = capture_count_q + 1'b1;
							res.scan_done        = !acq_n;
						end else begin
							acq_n         = 1'b0;
							res.scan_done = 1'b1;
						end
						if (res.scan_done) begin
							reading_n = 1'b0;
						end
					end
				end
				res.trigger_level = acquiring_q && phase_n;
			end
			MODE_START: begin
				count_n   = '0;
				reading_n = 1'b1;
				armed_n   = 1'b1;
				res.trigger_level = acq_n && phase_n;
			end
			MODE_TIMEOUT: begin
				if (timeout_armed_q) begin
					armed_n       = 1'b0;
					reading_n     = 1'b0;
					acq_n         = 1'b0;
					res.scan_done = 1'b1;
					res.timed_out = 1'b1;
				end
				res.trigger_level = acq_n && phase_n;
			end
			default: begin
				res.trigger_level = acq_n && phase_n;
			end
		endcase
		res.pulse_level = phase_n;
	end

	// Scan state advances once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_phase_q     <= 1'b0;
			reading_enabled_q <= 1'b0;
			acquiring_q       <= 1'b0;
			capture_count_q   <= '0;
			last_position_q   <= '0;
			timeout_armed_q   <= 1'b0;
		end else if (step) begin
			pulse_phase_q     <= phase_n;
			reading_enabled_q <= reading_n;
			acquiring_q       <= acq_n;
			capture_count_q   <= count_n;
			last_position_q   <= pos_n;
			timeout_armed_q   <= armed_n;
		end
	end

endmodule

FILE: tb/sv/wgpc_capture_checker.sv
// Checker for the window gated position capture unit: scan predictor and result compare.
module wgpc_capture_checker
	import wgpc_pkg::*;
#(
	parameter int CAPTURE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [MODE_W-1:0]      mode,
	input  logic [BYTE_W-1:0]      enc_high_byte,
	input  logic [BYTE_W-1:0]      enc_mid_byte,
	input  logic [BYTE_W-1:0]      enc_low_byte,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic                   pulse_level,
	input  logic                   trigger_level,
	input  logic                   trigdat_strobe,
	input  logic                   capture_valid,
	input  logic [IDX_W-1:0]       capture_index,
	input  logic [POS_W-1:0]       capture_position,
	input  logic                   scan_done,
	input  logic                   timed_out,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatch_count,
	output int                     results_outstanding,
	output int                     captures_seen,
	output int                     scans_ended,
	output int                     timeouts_seen
);

	// Predicted copy of the window registers and the scan state.
	logic [POS_W-1:0] window_low;
	logic [POS_W-1:0] window_high;
	logic             pulse_phase;
	logic             reading_enabled;
	logic             acquiring;
	int unsigned      capture_count;
	logic [POS_W-1:0] last_position;
	logic             timeout_armed;

	// Results predicted for accepted items, oldest first.
	result_t expected_scan_results[$];
	int      results_checked;

	task automatic report_mismatch(input string what);
		$display("%0t: result %0d: %s", $time, results_checked, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
		end
	endtask

	// Advances the scan state by one item and returns the result it produces.
	function automatic result_t advance_scan(input logic [MODE_W-1:0] md,
			input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] mid,
			input logic [BYTE_W-1:0] lo);
		result_t r;
		logic    was_acquiring;
		logic    finish;
		r = '0;
		if (md == MODE_TICK) begin
			was_acquiring = acquiring;
			pulse_phase = !pulse_phase;
			r.trigger_level = was_acquiring & pulse_phase;
			// Only a rising edge reads the encoder and captures.
			if (pulse_phase) begin
				r.trigdat_strobe = 1'b1;
				if (reading_enabled) begin
					last_position = {hi, mid, lo[7:4]};
					acquiring = (last_position >= window_low) && (last_position <= window_high);
				end
				if (was_acquiring) begin
					finish = 1'b1;
					timeout_armed = 1'b0;
					if (capture_count < CAPTURE_DEPTH) begin
						r.capture_valid = 1'b1;
						r.capture_index = capture_count[IDX_W-1:0];
						r.capture_position = last_position;
						capture_count++;
						if (acquiring) begin
							finish = 1'b0;
						end
					end else begin
						acquiring = 1'b0;
					end
					if (finish) begin
						reading_enabled = 1'b0;
						r.scan_done = 1'b1;
					end
				end
			end
		end else begin
			if (md == MODE_START) begin
				capture_count = 0;
				reading_enabled = 1'b1;
				timeout_armed = 1'b1;
			end else if (md == MODE_TIMEOUT) begin
				if (timeout_armed) begin
					timeout_armed = 1'b0;
					reading_enabled = 1'b0;
					acquiring = 1'b0;
					r.scan_done = 1'b1;
					r.timed_out = 1'b1;
				end
			end
			r.trigger_level = acquiring & pulse_phase;
		end
		r.pulse_level = pulse_phase;
		return r;
	endfunction

	// Watch both channels and the register port at every edge.
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			window_low = WINDOW_LOW_RESET;
			window_high = WINDOW_HIGH_RESET;
			pulse_phase = 1'b0;
			reading_enabled = 1'b0;
			acquiring = 1'b0;
			capture_count = 0;
			last_position = '0;
			timeout_armed = 1'b0;
			expected_scan_results.delete();
			results_checked = 0;
			mismatch_count = 0;
			captures_seen = 0;
			scans_ended = 0;
			timeouts_seen = 0;
			results_outstanding <= 0;
		end else begin
			// Register writes only happen while the unit is idle.
			if (cfg_write_en) begin
				if (cfg_index == REG_WINDOW_LOW) begin
					window_low = cfg_data[POS_W-1:0];
				end else if (cfg_index == REG_WINDOW_HIGH) begin
					window_high = cfg_data[POS_W-1:0];
				end
			end

			// Compare a result transfer against the oldest prediction.
			if (out_valid && out_ready) begin
				seen = {pulse_level, trigger_level, trigdat_strobe, capture_valid,
					capture_index, capture_position, scan_done, timed_out};
				if (expected_scan_results.size() == 0) begin
					report_mismatch("result transfer with no item waiting for it");
				end else begin
					want = expected_scan_results.pop_front();
					check_field("pulse_level", seen.pulse_level, want.pulse_level);
					check_field("trigger_level", seen.trigger_level, want.trigger_level);
					check_field("trigdat_strobe", seen.trigdat_strobe, want.trigdat_strobe);
					check_field("capture_valid", seen.capture_valid, want.capture_valid);
					check_field("capture_index", seen.capture_index, want.capture_index);
					check_field("capture_position", seen.capture_position,
						want.capture_position);
					check_field("scan_done", seen.scan_done, want.scan_done);
					check_field("timed_out", seen.timed_out, want.timed_out);
				end
				results_checked++;
			end

			// Predict the result of an input transfer.
			if (in_valid && in_ready) begin
				want = advance_scan(mode, enc_high_byte, enc_mid_byte, enc_low_byte);
				expected_scan_results.push_back(want);
				captures_seen += want.capture_valid;
				scans_ended += want.scan_done;
				timeouts_seen += want.timed_out;
			end

			results_outstanding <= expected_scan_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_window_gated_position_capture_unit.sv
// Testbench top for the window gated position capture unit: clock, reset and scan stimulus.
module tb_window_gated_position_capture_unit;
	import wgpc_pkg::*;

	// Mode 3 has no meaning and must leave the scan state alone.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int LONG_SCAN_TICKS = 530;
	localparam int DRAIN_CYCLES = 6;
	localparam int RUN_LIMIT = 400000;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [MODE_W-1:0]      mode = MODE_START;
	logic [BYTE_W-1:0]      enc_high_byte = '0;
	logic [BYTE_W-1:0]      enc_mid_byte = '0;
	logic [BYTE_W-1:0]      enc_low_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   pulse_level;
	logic                   trigger_level;
	logic                   trigdat_strobe;
	logic                   capture_valid;
	logic [IDX_W-1:0]       capture_index;
	logic [POS_W-1:0]       capture_position;
	logic                   scan_done;
	logic                   timed_out;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_WINDOW_LOW;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatch_count;
	int results_outstanding;
	int captures_seen;
	int scans_ended;
	int timeouts_seen;

	// Stimulus shaping: idle rates and the window the unit currently holds.
	int               tx_idle_pct = 0;
	int               rx_stall_pct = 0;
	int               items_sent = 0;
	int               window_settings = 1;
	logic [POS_W-1:0] win_lo = WINDOW_LOW_RESET;
	logic [POS_W-1:0] win_hi = WINDOW_HIGH_RESET;

	window_gated_position_capture_unit u_top (.*);

	wgpc_capture_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Holds one item on the input channel until its transfer.
	task automatic send_item(input logic [MODE_W-1:0] md, input logic [BYTE_W-1:0] hi,
			input logic [BYTE_W-1:0] mid, input logic [BYTE_W-1:0] lo);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		enc_high_byte <= hi;
		enc_mid_byte <= mid;
		enc_low_byte <= lo;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// A tick carrying an encoder position; the ignored low nibble is random.
	task automatic tick_at(input logic [POS_W-1:0] pos);
		logic [3:0] junk;
		junk = 4'($urandom_range(15));
		send_item(MODE_TICK, pos[19:12], pos[11:4], {pos[3:0], junk});
	endtask

	task automatic send_other(input logic [MODE_W-1:0] md);
		send_item(md, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
			BYTE_W'($urandom_range(255)));
	endtask

	// Mostly inside the window, sometimes just outside it or anywhere.
	function automatic logic [POS_W-1:0] pick_position();
		int               pick;
		logic [POS_W-1:0] span;
		pick = $urandom_range(99);
		span = win_hi - win_lo;
		if (win_lo <= win_hi && pick < 80) begin
			return win_lo + POS_W'($urandom_range(span));
		end else if (pick < 86) begin
			return win_lo - 1'b1;
		end else if (pick < 92) begin
			return win_hi + 1'b1;
		end
		return POS_W'($urandom);
	endfunction

	// One scan: a start, then ticks mixed with stray events.
	task automatic run_scan(input int max_ticks);
		int n;
		int pick;
		send_other(MODE_START);
		n = $urandom_range(max_ticks, 1);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_other(MODE_TIMEOUT);
			end else if (pick < 5) begin
				send_other(MODE_UNUSED);
			end else if (pick < 7) begin
				send_other(MODE_START);
			end else begin
				tick_at(pick_position());
			end
		end
		if ($urandom_range(99) < 30) begin
			send_other(MODE_TIMEOUT);
		end
	endtask

	// Wait until every predicted result has come out, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both window bounds on back-to-back edges.
	task automatic set_window(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_WINDOW_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_WINDOW_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		win_lo = lo;
		win_hi = hi;
		window_settings++;
	endtask

	// Overall time limit.
	initial begin
		#RUN_LIMIT;
		$display("timeout with %0d results still expected", results_outstanding);
		$display("tb_window_gated_position_capture_unit: done, errors");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int               lo_pick;
		int               hi_pick;
		logic [POS_W-1:0] pos;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 8;
		rx_stall_pct = 47;

		// Directed part with the reset window of 2080 to 2100.
		send_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		send_item(MODE_TIMEOUT, 8'h00, 8'h00, 8'h00);
		send_item(MODE_TICK, 8'hFF, 8'hFF, 8'hFF);
		send_item(MODE_TICK, 8'h00, 8'h00, 8'h00);
		send_other(MODE_START);
		tick_at(20'd2080);
		tick_at(20'd0);
		tick_at(20'd2100);
		send_other(MODE_START);
		tick_at(20'd0);
		tick_at(20'd2079);
		send_other(MODE_START);
		send_other(MODE_TIMEOUT);
		send_other(MODE_TIMEOUT);
		send_other(MODE_START);
		tick_at(20'hFFFFF);
		tick_at(20'd2101);
		tick_at(20'd0);
		tick_at(20'd2090);
		send_other(MODE_TIMEOUT);
		send_other(MODE_START);
		tick_at(20'd2095);
		tick_at(20'd0);
		tick_at(20'd2085);
		send_other(MODE_TIMEOUT);

		// Full window: one scan long enough to fill the capture buffer, then random scans.
		wait_idle();
		set_window(20'h00000, 20'hFFFFF);
		send_other(MODE_START);
		repeat (LONG_SCAN_TICKS) begin
			pos = POS_W'($urandom);
			tick_at(pos);
		end
		while (items_sent < 700) run_scan(24);

		// Receiver is now the fast side.
		wait_idle();
		tx_idle_pct = 47;
		rx_stall_pct = 8;
		set_window(20'h40000, 20'h40100);
		while (items_sent < 900) run_scan(24);
		// Low bound above high bound leaves the window empty.
		wait_idle();
		set_window(20'hFFFFF, 20'h00000);
		while (items_sent < 960) run_scan(12);
		wait_idle();
		set_window(20'hFFFFF, 20'hFFFFF);
		while (items_sent < 1020) run_scan(16);

		// No idling on either side.
		wait_idle();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		set_window(20'h00000, 20'h00000);
		while (items_sent < 1080) run_scan(16);
		wait_idle();
		lo_pick = $urandom_range(20'hFFFFF);
		hi_pick = lo_pick + $urandom_range(64);
		if (hi_pick > 20'hFFFFF) begin
			hi_pick = 20'hFFFFF;
		end
		set_window(POS_W'(lo_pick), POS_W'(hi_pick));
		while (items_sent < 1260) run_scan(24);

		wait_idle();
		$display("%0d items over %0d window settings, three idle patterns", items_sent,
			window_settings);
		$display("%0d positions captured, %0d scans ended, %0d of them by timeout",
			captures_seen, scans_ended, timeouts_seen);
		if (mismatch_count == 0) begin
			$display("tb_window_gated_position_capture_unit: done, clean");
		end else begin
			$display("tb_window_gated_position_capture_unit: done, errors");
		end
		$finish;
	end

endmodule

FILE: window_gated_position_capture_unit.f
+incdir+sv
sv/wgpc_pkg.sv
sv/wgpc_window.sv
sv/wgpc_ctrl.sv
sv/window_gated_position_capture_unit.sv
tb/sv/wgpc_capture_checker.sv
tb/sv/tb_window_gated_position_capture_unit.sv
